@@ sv/sspp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_pkg
// types and constants shared by the servo status packet parser
// ----------------------------------------------------------------------------
package sspp_pkg;

   localparam logic [7:0] START_BYTE = 8'hFF;
   localparam logic [7:0] MIN_LENGTH = 8'd2;

   localparam logic [1:0] KIND_PARAM = 2'd0;
   localparam logic [1:0] KIND_DONE  = 2'd1;
   localparam logic [1:0] KIND_EXTRA = 2'd2;

   typedef enum logic [2:0] {
      ST_HUNT1  = 3'd0,
      ST_HUNT2  = 3'd1,
      ST_ID     = 3'd2,
      ST_LEN    = 3'd3,
      ST_STATUS = 3'd4,
      ST_PARAM  = 3'd5,
      ST_CHECK  = 3'd6,
      ST_DONE   = 3'd7
   } parse_state_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       restart;
   } item_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] param_byte;
      logic [7:0] param_index;
      logic [7:0] servo_id;
      logic [7:0] servo_status;
      logic       checksum_ok;
      logic       framing_error;
      logic       length_mismatch;
      logic       last;
   } result_type;

endpackage
`default_nettype wire

@@ sv/sspp_in_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_in_stage
// input register; holds one received byte until the parser takes it
// ----------------------------------------------------------------------------
module sspp_in_stage (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output      logic              req_stall,
   input  wire sspp_pkg::item_type req_item,
   input  wire logic              advance,
   output      logic              item_valid,
   output      sspp_pkg::item_type item
);

   logic               valid_ff, valid_in;
   sspp_pkg::item_type item_ff, item_in;
   logic               load;

   assign load      = !valid_ff || advance;
   assign req_stall = valid_ff && !advance;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (load) begin
         valid_in = req_valid;
         item_in  = req_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

@@ sv/sspp_parser.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_parser
// packet state machine; one byte per step, at most one result per byte
// ----------------------------------------------------------------------------
module sspp_parser (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                fire,
   input  wire sspp_pkg::item_type  item,
   input  wire logic [7:0]          expected_count,
   output      logic                res_valid,
   output      sspp_pkg::result_type res
);

   sspp_pkg::parse_state_type state_ff, state_in, cur_state;
   logic [7:0] id_ff, id_in, cur_id;
   logic [7:0] len_ff, len_in, cur_len;
   logic [7:0] status_ff, status_in, cur_status;
   logic [7:0] sum_ff, sum_in, cur_sum;
   logic [7:0] seen_ff, seen_in, cur_seen;
   logic       err_ff, err_in, cur_err;
   logic [7:0] b;
   logic [7:0] param_count;
   logic [7:0] seen_next;

   assign b = item.rx_byte;

   // restart clears the parser before this byte is parsed
   always_comb begin
      if (item.restart) begin
         cur_state  = sspp_pkg::ST_HUNT1;
         cur_id     = 8'd0;
         cur_len    = 8'd0;
         cur_status = 8'd0;
         cur_sum    = 8'd0;
         cur_seen   = 8'd0;
         cur_err    = 1'b0;
      end else begin
         cur_state  = state_ff;
         cur_id     = id_ff;
         cur_len    = len_ff;
         cur_status = status_ff;
         cur_sum    = sum_ff;
         cur_seen   = seen_ff;
         cur_err    = err_ff;
      end
   end

   assign param_count = cur_len - sspp_pkg::MIN_LENGTH;
   assign seen_next   = cur_seen + 8'd1;

   // next state and field updates
   always_comb begin
      state_in  = cur_state;
      id_in     = cur_id;
      len_in    = cur_len;
      status_in = cur_status;
      sum_in    = cur_sum;
      seen_in   = cur_seen;
      err_in    = cur_err;
      unique case (cur_state)
         sspp_pkg::ST_HUNT1: begin
            state_in = (b == sspp_pkg::START_BYTE) ? sspp_pkg::ST_HUNT2
                                                    : sspp_pkg::ST_HUNT1;
         end
         sspp_pkg::ST_HUNT2: begin
            state_in = (b == sspp_pkg::START_BYTE) ? sspp_pkg::ST_ID
                                                    : sspp_pkg::ST_HUNT1;
         end
         sspp_pkg::ST_ID: begin
            if (b == sspp_pkg::START_BYTE) begin
               err_in   = 1'b1;
               state_in = sspp_pkg::ST_HUNT1;
            end else begin
               id_in     = b;
               status_in = 8'd0;
               sum_in    = b;
               seen_in   = 8'd0;
               state_in  = sspp_pkg::ST_LEN;
            end
         end
         sspp_pkg::ST_LEN: begin
            if (b < sspp_pkg::MIN_LENGTH) begin
               err_in   = 1'b1;
               state_in = sspp_pkg::ST_HUNT1;
            end else begin
               len_in   = b;
               sum_in   = cur_sum + b;
               state_in = sspp_pkg::ST_STATUS;
            end
         end
         sspp_pkg::ST_STATUS: begin
            status_in = b;
            sum_in    = cur_sum + b;
            seen_in   = 8'd0;
            state_in  = (cur_len == sspp_pkg::MIN_LENGTH) ? sspp_pkg::ST_CHECK
                                                           : sspp_pkg::ST_PARAM;
         end
         sspp_pkg::ST_PARAM: begin
            sum_in  = cur_sum + b;
            seen_in = seen_next;
            if (seen_next == param_count) begin
               state_in = sspp_pkg::ST_CHECK;
            end
         end
         sspp_pkg::ST_CHECK: begin
            state_in = sspp_pkg::ST_DONE;
         end
         sspp_pkg::ST_DONE: begin
            err_in = 1'b1;
         end
      endcase
   end

   // result for this byte
   always_comb begin
      res_valid           = 1'b0;
      res.kind            = sspp_pkg::KIND_PARAM;
      res.param_byte      = 8'd0;
      res.param_index     = 8'd0;
      res.servo_id        = cur_id;
      res.servo_status    = cur_status;
      res.checksum_ok     = 1'b0;
      res.framing_error   = cur_err;
      res.length_mismatch = 1'b0;
      res.last            = 1'b0;
      unique case (cur_state)
         sspp_pkg::ST_PARAM: begin
            res_valid       = 1'b1;
            res.param_byte  = b;
            res.param_index = cur_seen;
         end
         sspp_pkg::ST_CHECK: begin
            res_valid           = 1'b1;
            res.kind            = sspp_pkg::KIND_DONE;
            res.checksum_ok     = (~cur_sum == b);
            res.length_mismatch = (param_count != expected_count);
            res.last            = 1'b1;
         end
         sspp_pkg::ST_DONE: begin
            res_valid         = 1'b1;
            res.kind          = sspp_pkg::KIND_EXTRA;
            res.framing_error = 1'b1;
         end
         sspp_pkg::ST_HUNT1, sspp_pkg::ST_HUNT2, sspp_pkg::ST_ID,
         sspp_pkg::ST_LEN, sspp_pkg::ST_STATUS: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= sspp_pkg::ST_HUNT1;
         id_ff     <= 8'd0;
         len_ff    <= 8'd0;
         status_ff <= 8'd0;
         sum_ff    <= 8'd0;
         seen_ff   <= 8'd0;
         err_ff    <= 1'b0;
      end else if (fire) begin
         state_ff  <= state_in;
         id_ff     <= id_in;
         len_ff    <= len_in;
         status_ff <= status_in;
         sum_ff    <= sum_in;
         seen_ff   <= seen_in;
         err_ff    <= err_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/sspp_out_stage.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_out_stage
// result register; holds a result until the consumer takes it
// ----------------------------------------------------------------------------
module sspp_out_stage (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic                 res_valid,
   input  wire sspp_pkg::result_type res,
   input  wire logic                 rsp_stall,
   output      logic                 rsp_valid,
   output      sspp_pkg::result_type rsp_res,
   output      logic                 free
);

   logic                 valid_ff, valid_in;
   sspp_pkg::result_type res_ff, res_in;

   // room for a new result when empty or when the held one transfers now
   assign free = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      res_in   = res_ff;
      if (advance) begin
         valid_in = res_valid;
         res_in   = res;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      res_ff <= res_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

endmodule
`default_nettype wire

@@ sv/servo_status_packet_parser.sv @@
`default_nettype none
// a byte is taken into the input register; its result is made by the parser and held in the result register
// throughput: one byte per cycle while rsp_stall is low, set by the single parser state update
// a byte that ends no parameter, checksum or trailing slot gives no result
// a held result stalls input once the input register also holds a byte
// reset (synchronous, active high) clears parser state, register and valids
// ----------------------------------------------------------------------------
// servo_status_packet_parser
// parses servo status packets from a byte stream into parameter,
// packet-complete and trailing-byte results
// ----------------------------------------------------------------------------
module servo_status_packet_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_stall,
   input  wire logic [7:0] req_rx_byte,
   input  wire logic       req_restart,
   output      logic       rsp_valid,
   input  wire logic       rsp_stall,
   output      logic [1:0] rsp_kind,
   output      logic [7:0] rsp_param_byte,
   output      logic [7:0] rsp_param_index,
   output      logic [7:0] rsp_servo_id,
   output      logic [7:0] rsp_servo_status,
   output      logic       rsp_checksum_ok,
   output      logic       rsp_framing_error,
   output      logic       rsp_length_mismatch,
   output      logic       rsp_last,
   input  wire logic       csr_valid,
   output      logic       csr_ready,
   input  wire logic [7:0] csr_data
);

   sspp_pkg::item_type   req_item, item;
   sspp_pkg::result_type res, rsp_res;
   logic                 item_valid, advance, free, res_valid;
   logic [7:0]           expected_ff, expected_in;

   assign csr_ready   = 1'b1;
   assign expected_in = (csr_valid && csr_ready) ? csr_data : expected_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff <= 8'd0;
      end else begin
         expected_ff <= expected_in;
      end
   end

   assign req_item.rx_byte = req_rx_byte;
   assign req_item.restart = req_restart;

   // parser steps whenever the result register can take what it makes
   assign advance = item_valid && free;

   sspp_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   sspp_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .fire           (advance),
      .item           (item),
      .expected_count (expected_ff),
      .res_valid      (res_valid),
      .res            (res)
   );

   sspp_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .res_valid (res_valid),
      .res       (res),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_res   (rsp_res),
      .free      (free)
   );

   assign rsp_kind            = rsp_res.kind;
   assign rsp_param_byte      = rsp_res.param_byte;
   assign rsp_param_index     = rsp_res.param_index;
   assign rsp_servo_id        = rsp_res.servo_id;
   assign rsp_servo_status    = rsp_res.servo_status;
   assign rsp_checksum_ok     = rsp_res.checksum_ok;
   assign rsp_framing_error   = rsp_res.framing_error;
   assign rsp_length_mismatch = rsp_res.length_mismatch;
   assign rsp_last            = rsp_res.last;

endmodule
`default_nettype wire

@@ sv/sspp_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sspp_checker
// port-level checks of the result channel
// ----------------------------------------------------------------------------
module sspp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [1:0] rsp_kind,
   input wire logic [7:0] rsp_param_byte,
   input wire logic [7:0] rsp_param_index,
   input wire logic       rsp_checksum_ok,
   input wire logic       rsp_framing_error,
   input wire logic       rsp_length_mismatch,
   input wire logic       rsp_last
);

   // a stalled result holds until its transfer
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_param_byte) && $stable(rsp_param_index))
      else $error("stalled result changed");

   // last marks exactly the packet-complete result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind == sspp_pkg::KIND_DONE))
         && (rsp_kind != 2'd3))
      else $error("last does not match kind");

   // a trailing byte always reports the sticky framing error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == sspp_pkg::KIND_EXTRA) |-> rsp_framing_error
         && !rsp_checksum_ok && !rsp_length_mismatch)
      else $error("extra byte without framing error");

   // only parameter results carry a data byte and index
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind != sspp_pkg::KIND_PARAM) |->
         (rsp_param_byte == 8'd0) && (rsp_param_index == 8'd0))
      else $error("non-parameter result carries data");

   // no result comes straight out of reset
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("result valid right after reset");

endmodule

bind servo_status_packet_parser sspp_checker u_sspp_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_kind            (rsp_kind),
   .rsp_param_byte      (rsp_param_byte),
   .rsp_param_index     (rsp_param_index),
   .rsp_checksum_ok     (rsp_checksum_ok),
   .rsp_framing_error   (rsp_framing_error),
   .rsp_length_mismatch (rsp_length_mismatch),
   .rsp_last            (rsp_last)
);
`default_nettype wire
